[rtl/core/alpha_beta_tracker_3axis_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef ALPHA_BETA_TRACKER_3AXIS_TOP_MACROS_SVH
`define ALPHA_BETA_TRACKER_3AXIS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABT3_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ABT3_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("tracker assertion failed");

`endif

[rtl/core/abt3_pkg.sv]
package abt3_pkg;

    localparam int NUM_AXES    = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int GAIN_WIDTH  = 16;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [GAIN_WIDTH-1:0]         gain_t;

    // Register indexes on the APB port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_POSITION_GAIN = 2'd0,
        REG_VELOCITY_GAIN = 2'd1,
        REG_TIME_STEP     = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    localparam gain_t POSITION_GAIN_RST = 16'd11889;
    localparam gain_t VELOCITY_GAIN_RST = 16'd593;
    localparam gain_t TIME_STEP_RST     = 16'd3277;

    typedef enum logic {
        ACT_MEASURE = 1'b0,
        ACT_PREDICT = 1'b1
    } action_t;

    typedef struct packed {
        logic   action;
        value_t meas_x;
        value_t meas_y;
        value_t meas_z;
        value_t ref_x;
        value_t ref_y;
        value_t ref_z;
    } in_item_t;

    typedef struct packed {
        value_t est_pos_x;
        value_t est_pos_y;
        value_t est_pos_z;
        value_t est_vel_x;
        value_t est_vel_y;
        value_t est_vel_z;
    } out_item_t;

    typedef struct packed {
        gain_t position_gain;
        gain_t velocity_gain;
        gain_t time_step;
    } cfg_t;

    // Controller to datapath step strobes
    typedef struct packed {
        logic load;
        logic resid;
        logic mulc;
        logic corr;
        logic mulp;
        logic commit;
    } cmd_t;

endpackage

[rtl/core/abt3_ctrl.sv]
module abt3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_action,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output abt3_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESID,
        ST_MULC,
        ST_CORR,
        ST_MULP,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequence the datapath steps
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load = 1'b1;
                    if (in_action == abt3_pkg::ACT_PREDICT)
                        state_next = ST_MULP;
                    else
                        state_next = ST_RESID;
                end
            end
            ST_RESID:
            begin
                cmd.resid  = 1'b1;
                state_next = ST_MULC;
            end
            ST_MULC:
            begin
                cmd.mulc   = 1'b1;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                cmd.mulp   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/abt3_datapath.sv]
module abt3_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  abt3_pkg::cmd_t        cmd,
    input  abt3_pkg::cfg_t        cfg,
    input  abt3_pkg::in_item_t    in_data,
    output abt3_pkg::out_item_t   out_data
);

    localparam int VW     = abt3_pkg::VALUE_WIDTH;
    localparam int GW     = abt3_pkg::GAIN_WIDTH;
    localparam int NA     = abt3_pkg::NUM_AXES;
    localparam int PROD_W = VW + GW + 1;
    localparam int RND_W  = PROD_W - GW + 1;

    typedef logic signed [PROD_W-1:0] prod_t;

    // Exact add, then clamp to the signed value range
    function automatic abt3_pkg::value_t add_sat(input abt3_pkg::value_t a,
                                                 input abt3_pkg::value_t b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1])
            return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        return s[VW-1:0];
    endfunction

    function automatic abt3_pkg::value_t sub_sat(input abt3_pkg::value_t a,
                                                 input abt3_pkg::value_t b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1])
            return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        return s[VW-1:0];
    endfunction

    // Round half up to Q16.16 (floor of (p + 2^15) / 2^16), then clamp
    function automatic abt3_pkg::value_t round_sat(input prod_t p);
        logic signed [PROD_W:0]  s;
        logic signed [RND_W-1:0] q;
        s = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (GW - 1));
        q = s[PROD_W:GW];
        // Out of range when the bits above the value's sign bit disagree with it
        if (q[RND_W-1:VW-1] != {(RND_W-VW+1){q[RND_W-1]}})
            return q[RND_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        return q[VW-1:0];
    endfunction

    function automatic prod_t mul_gain(input abt3_pkg::value_t v,
                                       input abt3_pkg::gain_t g);
        logic signed [GW:0] gs;
        gs = {1'b0, g};
        return prod_t'(v) * prod_t'(gs);
    endfunction

    abt3_pkg::value_t meas [NA];
    abt3_pkg::value_t refv [NA];

    abt3_pkg::value_t diff_reg  [NA];
    abt3_pkg::value_t resid_reg [NA];
    prod_t            pa_reg    [NA];
    prod_t            pb_reg    [NA];
    prod_t            pt_reg    [NA];
    abt3_pkg::value_t pos_w_reg [NA];
    abt3_pkg::value_t vel_w_reg [NA];
    abt3_pkg::value_t pos_s_reg [NA];
    abt3_pkg::value_t vel_s_reg [NA];
    abt3_pkg::value_t pos_o_reg [NA];
    abt3_pkg::value_t vel_o_reg [NA];

    assign meas[0] = in_data.meas_x;
    assign meas[1] = in_data.meas_y;
    assign meas[2] = in_data.meas_z;
    assign refv[0] = in_data.ref_x;
    assign refv[1] = in_data.ref_y;
    assign refv[2] = in_data.ref_z;

    assign out_data.est_pos_x = pos_o_reg[0];
    assign out_data.est_pos_y = pos_o_reg[1];
    assign out_data.est_pos_z = pos_o_reg[2];
    assign out_data.est_vel_x = vel_o_reg[0];
    assign out_data.est_vel_y = vel_o_reg[1];
    assign out_data.est_vel_z = vel_o_reg[2];

    for (genvar a = 0; a < NA; a++)
    begin : g_lane
        // Working values: one step per controller strobe
        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                diff_reg[a]  <= sub_sat(meas[a], refv[a]);
                pos_w_reg[a] <= pos_s_reg[a];
                vel_w_reg[a] <= vel_s_reg[a];
            end
            if (cmd.resid)
                resid_reg[a] <= sub_sat(diff_reg[a], pos_w_reg[a]);
            if (cmd.mulc)
            begin
                pa_reg[a] <= mul_gain(resid_reg[a], cfg.position_gain);
                pb_reg[a] <= mul_gain(resid_reg[a], cfg.velocity_gain);
            end
            if (cmd.corr)
            begin
                pos_w_reg[a] <= add_sat(pos_w_reg[a], round_sat(pa_reg[a]));
                vel_w_reg[a] <= add_sat(vel_w_reg[a], round_sat(pb_reg[a]));
            end
            if (cmd.mulp)
                pt_reg[a] <= mul_gain(vel_w_reg[a], cfg.time_step);
            if (cmd.commit)
            begin
                pos_o_reg[a] <= pos_w_reg[a];
                vel_o_reg[a] <= vel_w_reg[a];
            end
        end

        // Tracker state: propagate position on commit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_s_reg[a] <= '0;
                vel_s_reg[a] <= '0;
            end
            else if (cmd.commit)
            begin
                pos_s_reg[a] <= add_sat(pos_w_reg[a], round_sat(pt_reg[a]));
                vel_s_reg[a] <= vel_w_reg[a];
            end
        end
    end

endmodule

[rtl/core/alpha_beta_tracker_3axis_top.sv]
// Three-axis alpha-beta tracker, signed Q16.16 values, unsigned Q0.16 gains.
// Input channel (in_valid / in_stall / in_data): one transfer per item.
// action 0 corrects each axis with the measurement, action 1 only predicts.
// Output channel (out_valid / out_stall / out_data): one transfer per item,
// carrying position before propagation and velocity.
// A measurement item runs the controller's step sequence: residual,
// gain multiply, correction, dt multiply, commit; a predict item runs only
// the dt multiply and the commit. The next item is taken only after the
// result is registered.
// A finished result waits in the output register; a new item is taken while
// it waits, and its commit holds while the receiver keeps out_stall high.
// Reset clears the tracker state to zero and loads the default gains
// (alpha 11889, beta 593, dt 3277). Registers sit on an APB port at byte
// addresses 0, 4 and 8; write them only while the block is idle.
module alpha_beta_tracker_3axis_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  abt3_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output abt3_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abt3_pkg::APB_AW-1:0]   paddr,
    input  logic [abt3_pkg::APB_DW-1:0]   pwdata,
    output logic [abt3_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    abt3_pkg::cfg_t     cfg_reg;
    abt3_pkg::cmd_t     cmd;
    abt3_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = abt3_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes; the unused slot is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_gain <= abt3_pkg::POSITION_GAIN_RST;
            cfg_reg.velocity_gain <= abt3_pkg::VELOCITY_GAIN_RST;
            cfg_reg.time_step     <= abt3_pkg::TIME_STEP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                abt3_pkg::REG_POSITION_GAIN:
                    cfg_reg.position_gain <= pwdata[abt3_pkg::GAIN_WIDTH-1:0];
                abt3_pkg::REG_VELOCITY_GAIN:
                    cfg_reg.velocity_gain <= pwdata[abt3_pkg::GAIN_WIDTH-1:0];
                abt3_pkg::REG_TIME_STEP:
                    cfg_reg.time_step     <= pwdata[abt3_pkg::GAIN_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            abt3_pkg::REG_POSITION_GAIN:
                prdata = abt3_pkg::APB_DW'(cfg_reg.position_gain);
            abt3_pkg::REG_VELOCITY_GAIN:
                prdata = abt3_pkg::APB_DW'(cfg_reg.velocity_gain);
            abt3_pkg::REG_TIME_STEP:
                prdata = abt3_pkg::APB_DW'(cfg_reg.time_step);
            default:
                prdata = '0;
        endcase
    end

    abt3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    abt3_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

[rtl/core/abt3_checker.sv]
`include "alpha_beta_tracker_3axis_top_macros.svh"

module abt3_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input abt3_pkg::out_item_t out_data
);

    // One item at a time: a transfer closes the input until its result is out
    `ABT3_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // A new result only appears at the end of an item's work
    `ABT3_ASSERT_IMPLY(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A stalled result stays offered and unchanged
    `ABT3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ABT3_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind alpha_beta_tracker_3axis_top abt3_checker u_abt3_checker (.*);

[test/tb_alpha_beta_tracker_3axis_top.sv]
module tb_alpha_beta_tracker_3axis_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abt3_pkg::*;

    localparam int     N_FIELDS       = 2 * NUM_AXES;
    localparam int     GAP_MAX        = 10;
    localparam int     HOLD_LEN       = 80;
    localparam int     SETTLE_CYCLES  = 10;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PRINT_LIMIT    = 50;
    localparam longint SAT_HI         = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint SAT_LO         = -SAT_HI - 1;
    localparam value_t V_MAX          = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t V_MIN          = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam value_t V_ONE          = 32'sh0001_0000;
    localparam gain_t  GAIN_MAX       = 16'hFFFF;
    localparam gain_t  GAIN_HALF      = 16'h8000;

    typedef struct {
        in_item_t item;
        bit       drain;
    } pending_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    in_item_t            in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // tracker state and gains as the block should hold them
    longint    track_pos [NUM_AXES];
    longint    track_vel [NUM_AXES];
    gain_t     gain_pos = POSITION_GAIN_RST;
    gain_t     gain_vel = VELOCITY_GAIN_RST;
    gain_t     step_dt  = TIME_STEP_RST;

    pending_t  item_q [$];
    out_item_t est_q [$];

    int  sent_cnt     = 0;
    int  got_cnt      = 0;
    int  n_meas       = 0;
    int  n_pred       = 0;
    int  n_writes     = 0;
    int  errors       = 0;
    int  quiet_cycles = 0;
    int  hold_req     = 0;
    int  hold_seen    = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    int  hold_left    = 0;
    bit  tx_idle      = 1'b1;
    bit  rx_idle      = 1'b1;

    alpha_beta_tracker_3axis_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_error(string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic longint clamp(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // Q16.16 times Q0.16, round half up, saturate
    function automatic longint apply_gain(longint v, gain_t g);
        longint p;
        p = v * longint'({48'd0, g}) + 64'sd32768;
        return clamp(p >>> 16);
    endfunction

    // correct (measurement only), emit estimate, then propagate position
    task automatic track_step(input in_item_t it, output out_item_t est);
        value_t meas [NUM_AXES];
        value_t offs [NUM_AXES];
        longint pos;
        longint vel;
        longint resid;
        meas = '{it.meas_x, it.meas_y, it.meas_z};
        offs = '{it.ref_x, it.ref_y, it.ref_z};
        est  = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pos = track_pos[a];
            vel = track_vel[a];
            if (it.action == ACT_MEASURE)
            begin
                resid = clamp(clamp(longint'(meas[a]) - longint'(offs[a])) - pos);
                pos   = clamp(pos + apply_gain(resid, gain_pos));
                vel   = clamp(vel + apply_gain(resid, gain_vel));
            end
            est[(N_FIELDS-1-a)*VALUE_WIDTH +: VALUE_WIDTH] = pos[VALUE_WIDTH-1:0];
            est[(NUM_AXES-1-a)*VALUE_WIDTH +: VALUE_WIDTH] = vel[VALUE_WIDTH-1:0];
            track_pos[a] = clamp(pos + apply_gain(vel, step_dt));
            track_vel[a] = vel;
        end
    endtask

    task automatic compare_estimate(out_item_t got, out_item_t want, int idx);
        string  fname [N_FIELDS];
        value_t g;
        value_t w;
        fname = '{"est_pos_x", "est_pos_y", "est_pos_z",
                  "est_vel_x", "est_vel_y", "est_vel_z"};
        for (int f = 0; f < N_FIELDS; f++)
        begin
            g = got[(N_FIELDS-1-f)*VALUE_WIDTH +: VALUE_WIDTH];
            w = want[(N_FIELDS-1-f)*VALUE_WIDTH +: VALUE_WIDTH];
            if (g !== w)
                report_error($sformatf("estimate %0d %s: got %h, want %h",
                                       idx, fname[f], g, w));
        end
    endtask

    // Drive input transfers from the pending queue, predicting each accepted one
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        pending_t  nxt;
        out_item_t est;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_wait  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_step(in_data, est);
                est_q.push_back(est);
                sent_cnt++;
                if (in_data.action == ACT_MEASURE)
                    n_meas++;
                else
                    n_pred++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() > 0 && !(item_q[0].drain && sent_cnt != got_cnt))
                begin
                    nxt      = item_q.pop_front();
                    in_data  <= nxt.item;
                    in_valid <= 1'b1;
                    tx_wait  = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check result transfers and drive the receiver's stall
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_cnt <= got_cnt + 1;
                if (est_q.size() == 0)
                    report_error($sformatf("result with no estimate pending: %h", out_data));
                else
                begin
                    want = est_q.pop_front();
                    compare_estimate(out_data, want, got_cnt);
                end
                rx_wait = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("tb_alpha_beta_tracker_3axis_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // APB write: setup cycle, access cycle, register takes the value at the access edge
    task automatic write_reg(reg_idx_t idx, gain_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POSITION_GAIN: gain_pos = val;
            REG_VELOCITY_GAIN: gain_vel = val;
            REG_TIME_STEP:     step_dt  = val;
            default:           ;
        endcase
        n_writes++;
        @(negedge clk);
    endtask

    task automatic set_gains(gain_t alpha, gain_t beta, gain_t dt);
        write_reg(REG_POSITION_GAIN, alpha);
        write_reg(REG_VELOCITY_GAIN, beta);
        write_reg(REG_TIME_STEP, dt);
        // the unused index must leave the gains alone
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Hold until the block is empty, then let it settle
    task automatic wait_drained();
        @(negedge clk);
        while (item_q.size() != 0 || in_valid || est_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_item(in_item_t it, bit drain);
        pending_t p;
        p.item  = it;
        p.drain = drain;
        item_q.push_back(p);
    endtask

    function automatic in_item_t pack_item(action_t act, value_t mx, value_t my, value_t mz,
                                           value_t rx, value_t ry, value_t rz);
        in_item_t it;
        it.action = act;
        it.meas_x = mx;
        it.meas_y = my;
        it.meas_z = mz;
        it.ref_x  = rx;
        it.ref_y  = ry;
        it.ref_z  = rz;
        return it;
    endfunction

    function automatic value_t extreme_value();
        case ($urandom_range(0, 4))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return '0;
            3:       return '1;
            default: return V_ONE;
        endcase
    endfunction

    // Mostly a target moving at constant speed with offsets and noise,
    // plus predict ticks, raw random measurements and extremes
    task automatic queue_random(int count);
        longint   truth [NUM_AXES];
        longint   speed [NUM_AXES];
        longint   offs;
        longint   noise;
        value_t   m [NUM_AXES];
        value_t   r [NUM_AXES];
        int       kind;
        in_item_t it;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            truth[a] = longint'($urandom_range(0, 2**27)) - 2**26;
            speed[a] = longint'($urandom_range(0, 2**19)) - 2**18;
        end
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                truth[a] += speed[a];
                if (kind < 60)
                begin
                    offs = longint'($urandom_range(0, 2**21)) - 2**20;
                    noise = longint'($urandom_range(0, 2**13)) - 2**12;
                    r[a] = value_t'(offs);
                    m[a] = value_t'(truth[a] + offs + noise);
                end
                else if (kind < 95)
                begin
                    r[a] = value_t'($urandom);
                    m[a] = value_t'($urandom);
                end
                else
                begin
                    r[a] = extreme_value();
                    m[a] = extreme_value();
                end
            end
            it = pack_item((kind >= 60 && kind < 80) ? ACT_PREDICT : ACT_MEASURE,
                           m[0], m[1], m[2], r[0], r[1], r[2]);
            queue_item(it, $urandom_range(0, 29) == 0);
        end
    endtask

    initial
    begin : main_seq
        for (int a = 0; a < NUM_AXES; a++)
        begin
            track_pos[a] = 0;
            track_vel[a] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: default gains, plain values, residual saturation both ways
        queue_item(pack_item(ACT_MEASURE, V_ONE, 2 * V_ONE, -3 * V_ONE, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '1, '1, '1, '1, '1, '1), 1'b0);
        queue_item(pack_item(ACT_MEASURE, V_MAX, V_MIN, '1, V_MIN, V_MAX, V_ONE), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_MEASURE, '0, '0, '0, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_MEASURE, '1, '1, '1, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_MEASURE, V_MAX, V_MAX, V_MAX, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_PREDICT, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b1);
        wait_drained();

        // full gains: drive velocity and propagated position into the rails
        set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        queue_item(pack_item(ACT_MEASURE, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN, V_MAX), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_MEASURE, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        wait_drained();

        // half gains: rounding ties on positive and negative products
        set_gains(GAIN_HALF, GAIN_HALF, GAIN_HALF);
        queue_item(pack_item(ACT_MEASURE, 32'sd1, -32'sd1, 32'sd3, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_MEASURE, -32'sd3, 32'sd5, -32'sd1, '0, '0, '0), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        wait_drained();

        // zero gains: nothing corrects, nothing propagates
        set_gains('0, '0, '0);
        queue_item(pack_item(ACT_MEASURE, V_MAX, V_MIN, V_ONE, '1, V_ONE, '0), 1'b0);
        queue_item(pack_item(ACT_PREDICT, '0, '0, '0, '0, '0, '0), 1'b0);
        wait_drained();

        // random phases: back to back, heavy stalls, long receiver hold, extremes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       set_gains(16'($urandom), 16'($urandom), 16'($urandom));
                1:       set_gains(GAIN_MAX, GAIN_MAX, '0);
                2:       set_gains('0, GAIN_MAX, GAIN_MAX);
                5:       set_gains(GAIN_MAX, '0, GAIN_MAX);
                default: set_gains(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            tx_idle = (ph != 0);
            rx_idle = (ph != 0);
            queue_random(100);
            if (ph == 3)
                hold_req++;
            wait_drained();
        end

        $display("Covered %0d measurement and %0d predict transfers over %0d register writes,",
                 n_meas, n_pred, n_writes);
        $display("including saturation, rounding ties, gain extremes and stall pressure.");
        if (errors == 0)
            $display("tb_alpha_beta_tracker_3axis_top OK");
        else
            $display("tb_alpha_beta_tracker_3axis_top NOT OK");
        $finish;
    end

endmodule
